// ----- hw/rtl/cdcc_pkg.sv -----
// Shared types, constants and helpers of the corrected DCC correlation update block.
`default_nettype none

package cdcc_pkg;

    // Default structure of the block
    localparam int SERIES_DEF  = 4;
    localparam int FRAC_DEF    = 16;

    // Fixed field and port widths
    localparam int DW          = 32;
    localparam int W_FRAC      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 16;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 72;

    // Register reset values
    localparam logic [CFG_W-1:0] ALPHA_RST = 16'd3277;
    localparam logic [CFG_W-1:0] BETA_RST  = 16'd58982;
    localparam logic [CFG_W-1:0] SKIP_RST  = 16'd1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA = 2'd0,
        REG_BETA  = 2'd1,
        REG_SKIP  = 2'd2
    } cfg_reg_t;

    // Input item kinds
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ELEM = 1'b1;

    // Status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SK_RD,
        ST_SK_EMIT,
        ST_U_RD,
        ST_U_SQ,
        ST_U_SQW,
        ST_U_ST,
        ST_Q_LI,
        ST_Q_RD,
        ST_Q_NEWS,
        ST_Q_C,
        ST_Q_A,
        ST_Q_B,
        ST_D_RD,
        ST_D_SQ,
        ST_D_SQW,
        ST_R_LI,
        ST_R_RD,
        ST_R_DEN,
        ST_R_DIVW,
        ST_R_T,
        ST_R_H,
        ST_R_EMIT,
        ST_FINISH
    } state_t;

    // Saturate a 64-bit signed value to 32-bit signed
    function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] x);
        logic signed [DW-1:0] r;
        if (x > 64'sh000000007fffffff)
            r = 32'sh7fffffff;
        else if (x < 64'shffffffff80000000)
            r = 32'sh80000000;
        else
            r = x[DW-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/corrected_dcc_correlation_update.sv -----
// Top level: corrected DCC recursion sequencer with shared multiplier, sqrt and divider.
//
//  channel  | dir | handshake          | content
//  s_*      | in  | s_tvalid/s_tready  | tuser operation, tdata fields, tlast period_end
//  m_*      | out | m_tvalid/m_tready  | tdata R/H entry, tlast last entry of period
//  wr_*     | in  | wr_en              | register index and data, no read-back
//
// Load items and elements that do not close a period are taken while idle.
// A closing element in a skipped period reads and emits each upper-triangle entry of S.
// An update period walks the diagonal, the full square, the diagonal again and the
// upper triangle; its length is set by the serial square root and divider.
// Reset clears Q to identity through valid bits; no clearing pass is needed.
// A stalled output holds the sequencer at its emit step; input waits meanwhile.
`default_nettype none

module corrected_dcc_correlation_update #(
    parameter int SERIES    = cdcc_pkg::SERIES_DEF,
    parameter int FRAC_BITS = cdcc_pkg::FRAC_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // row[2:0] col[5:3] cov_value[37:6] residual[69:38] volatility[101:70]
    input  wire logic [cdcc_pkg::IN_TDATA_W-1:0]    s_tdata,
    // operation
    input  wire logic                               s_tuser,
    input  wire logic                               s_tlast,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // out_row[2:0] out_col[5:3] correlation[37:6] covariance[69:38]
    output logic [cdcc_pkg::OUT_TDATA_W-1:0]        m_tdata,
    output logic                                    m_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               wr_en,
    input  wire logic [cdcc_pkg::CFG_IDX_W-1:0]     wr_index,
    input  wire logic [cdcc_pkg::CFG_W-1:0]         wr_data
);
    import cdcc_pkg::*;

    localparam int NN   = SERIES * SERIES;
    localparam int IDXW = (SERIES > 1) ? $clog2(SERIES) : 1;
    localparam int AW   = $clog2(NN);
    localparam logic [IDXW-1:0] IDX_LAST = IDXW'(SERIES - 1);
    localparam logic signed [DW-1:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

    function automatic logic [AW-1:0] addr_of(input logic [IDXW-1:0] r,
                                              input logic [IDXW-1:0] c);
        return AW'(r) * AW'(SERIES) + AW'(c);
    endfunction

    // Input unpack
    logic [2:0]           in_row;
    logic [2:0]           in_col;
    logic signed [DW-1:0] in_cov;
    logic signed [DW-1:0] in_res;
    logic signed [DW-1:0] in_vol;
    logic                 in_accept;
    logic                 row_ok;
    logic                 col_ok;

    assign in_row    = s_tdata[2:0];
    assign in_col    = s_tdata[5:3];
    assign in_cov    = s_tdata[37:6];
    assign in_res    = s_tdata[69:38];
    assign in_vol    = s_tdata[101:70];
    assign in_accept = s_tvalid && s_tready;
    assign row_ok    = ({1'b0, in_row} < 4'(SERIES));
    assign col_ok    = ({1'b0, in_col} < 4'(SERIES));

    // Configuration registers
    logic [CFG_W-1:0] alpha_reg;
    logic [CFG_W-1:0] beta_reg;
    logic [CFG_W-1:0] skip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RST;
            beta_reg  <= BETA_RST;
            skip_reg  <= SKIP_RST;
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                REG_ALPHA: alpha_reg <= wr_data;
                REG_BETA:  beta_reg  <= wr_data;
                REG_SKIP:  skip_reg  <= wr_data;
                default:   ;
            endcase
        end
    end

    // State and sequencer registers
    state_t               state_reg;
    state_t               state_next;
    logic [IDXW-1:0]      i_reg;
    logic [IDXW-1:0]      j_reg;
    logic [15:0]          period_count_reg;

    // Memories and small per-series stores
    logic signed [DW-1:0] s_mem [NN];
    logic signed [DW-1:0] q_mem [NN];
    logic [NN-1:0]        q_valid_reg;
    logic signed [DW-1:0] s_rd_reg;
    logic signed [DW-1:0] q_rd_reg;
    logic                 q_rdv_reg;
    logic                 q_rdd_reg;
    logic signed [DW-1:0] cur_res [SERIES];
    logic signed [DW-1:0] cur_vol [SERIES];
    logic signed [DW-1:0] prev_res_reg [SERIES];
    logic signed [DW-1:0] u_arr [SERIES];
    logic signed [DW-1:0] d_arr [SERIES];

    // Arithmetic registers
    logic signed [63:0]   prod_reg;
    logic signed [63:0]   acc_reg;
    logic signed [DW-1:0] lat_reg;
    logic signed [DW-1:0] news_reg;
    logic signed [DW-1:0] r_reg;

    // Output slot
    logic                 m_tvalid_reg;
    logic [2:0]           out_row_reg;
    logic [2:0]           out_col_reg;
    logic signed [DW-1:0] out_corr_reg;
    logic signed [DW-1:0] out_cov_reg;
    logic                 out_last_reg;

    // Serial units
    logic                 sq_start;
    logic                 div_start;
    unit_stat_t           sq_stat;
    unit_stat_t           div_stat;
    logic [DW-1:0]        sq_root;
    logic signed [DW-1:0] div_quo;

    // Combinational helpers
    logic [AW-1:0]        rd_addr;
    logic signed [DW-1:0] q_val;
    logic [IDXW-1:0]      sel_idx;
    logic signed [DW-1:0] u_sel;
    logic signed [DW-1:0] d_sel;
    logic signed [DW-1:0] prev_sel;
    logic signed [DW-1:0] vol_sel;
    logic signed [DW-1:0] c_val;
    logic signed [DW-1:0] a_val;
    logic signed [DW-1:0] b_val;
    logic signed [DW-1:0] t_val;
    logic signed [63:0]   prod_sh;
    logic signed [63:0]   q_sum;
    logic signed [DW-1:0] q_new;
    logic                 den_pos;
    logic signed [DW-1:0] mul_a;
    logic signed [DW-1:0] mul_b;
    logic                 mul_en;
    logic                 out_free;
    logic                 emit;
    logic                 idx_i_last;
    logic                 idx_j_last;
    logic                 tri_last;

    assign rd_addr    = addr_of(i_reg, j_reg);
    assign q_val      = q_rdv_reg ? q_rd_reg : (q_rdd_reg ? ONE_Q : '0);
    assign prod_sh    = prod_reg >>> FRAC_BITS;
    assign q_sum      = acc_reg + prod_reg;
    assign q_new      = sat32(q_sum >>> W_FRAC);
    assign t_val      = sat32(prod_sh);
    assign den_pos    = (prod_sh > 64'sd0);
    assign a_val      = $signed({16'd0, alpha_reg});
    assign b_val      = $signed({16'd0, beta_reg});
    assign c_val      = 32'sd65536 - a_val - b_val;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign idx_i_last = (i_reg == IDX_LAST);
    assign idx_j_last = (j_reg == IDX_LAST);
    assign tri_last   = idx_i_last && idx_j_last;

    // Single read index into the per-series stores
    always_comb
    begin
        unique case (state_reg)
            ST_Q_RD, ST_R_RD, ST_R_H: sel_idx = j_reg;
            default:                  sel_idx = i_reg;
        endcase
        u_sel    = u_arr[sel_idx];
        d_sel    = d_arr[sel_idx];
        prev_sel = prev_res_reg[sel_idx];
        vol_sel  = cur_vol[sel_idx];
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_U_SQW:  begin mul_a = $signed(sq_root); mul_b = prev_sel; end
            ST_Q_RD:   begin mul_a = lat_reg;          mul_b = u_sel;    end
            ST_Q_NEWS: begin mul_a = c_val;            mul_b = s_rd_reg; end
            ST_Q_C:    begin mul_a = a_val;            mul_b = news_reg; end
            ST_Q_A:    begin mul_a = b_val;            mul_b = q_val;    end
            ST_R_RD:   begin mul_a = lat_reg;          mul_b = d_sel;    end
            ST_R_T:    begin mul_a = vol_sel;          mul_b = r_reg;    end
            ST_R_H:    begin mul_a = t_val;            mul_b = vol_sel;  end
            default:   mul_en = 1'b0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_tuser == OP_ELEM) && s_tlast)
                    state_next = ({1'b0, period_count_reg} < {1'b0, skip_reg})
                                 ? ST_SK_RD : ST_U_RD;
            end
            ST_SK_RD:   state_next = ST_SK_EMIT;
            ST_SK_EMIT:
            begin
                if (out_free)
                    state_next = tri_last ? ST_FINISH : ST_SK_RD;
            end
            ST_U_RD:    state_next = ST_U_SQ;
            ST_U_SQ:    state_next = ST_U_SQW;
            ST_U_SQW:   if (sq_stat.done) state_next = ST_U_ST;
            ST_U_ST:    state_next = idx_i_last ? ST_Q_LI : ST_U_RD;
            ST_Q_LI:    state_next = ST_Q_RD;
            ST_Q_RD:    state_next = ST_Q_NEWS;
            ST_Q_NEWS:  state_next = ST_Q_C;
            ST_Q_C:     state_next = ST_Q_A;
            ST_Q_A:     state_next = ST_Q_B;
            ST_Q_B:     state_next = tri_last ? ST_D_RD : ST_Q_LI;
            ST_D_RD:    state_next = ST_D_SQ;
            ST_D_SQ:    state_next = ST_D_SQW;
            ST_D_SQW:
            begin
                if (sq_stat.done)
                    state_next = idx_i_last ? ST_R_LI : ST_D_RD;
            end
            ST_R_LI:    state_next = ST_R_RD;
            ST_R_RD:    state_next = ST_R_DEN;
            ST_R_DEN:   state_next = den_pos ? ST_R_DIVW : ST_R_T;
            ST_R_DIVW:  if (div_stat.done) state_next = ST_R_T;
            ST_R_T:     state_next = ST_R_H;
            ST_R_H:     state_next = ST_R_EMIT;
            ST_R_EMIT:
            begin
                if (out_free)
                    state_next = tri_last ? ST_FINISH : ST_R_LI;
            end
            ST_FINISH:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        sq_start  = (state_reg == ST_U_SQ) || (state_reg == ST_D_SQ);
        div_start = (state_reg == ST_R_DEN) && den_pos;
        emit      = ((state_reg == ST_SK_EMIT) || (state_reg == ST_R_EMIT)) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Index counters: diagonal, full square and upper triangle walks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE, ST_FINISH:
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                end
                ST_U_ST:
                begin
                    i_reg <= idx_i_last ? '0 : i_reg + 1'b1;
                    j_reg <= idx_i_last ? '0 : i_reg + 1'b1;
                end
                ST_D_SQW:
                begin
                    if (sq_stat.done)
                    begin
                        i_reg <= idx_i_last ? '0 : i_reg + 1'b1;
                        j_reg <= idx_i_last ? '0 : i_reg + 1'b1;
                    end
                end
                ST_Q_B:
                begin
                    if (idx_j_last)
                    begin
                        i_reg <= idx_i_last ? '0 : i_reg + 1'b1;
                        j_reg <= '0;
                    end
                    else
                        j_reg <= j_reg + 1'b1;
                end
                ST_SK_EMIT, ST_R_EMIT:
                begin
                    if (out_free && !tri_last)
                    begin
                        if (idx_j_last)
                        begin
                            i_reg <= i_reg + 1'b1;
                            j_reg <= i_reg + 1'b1;
                        end
                        else
                            j_reg <= j_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // S and Q memories, registered read
    always_ff @(posedge clk)
    begin
        if (in_accept && (s_tuser == OP_LOAD) && row_ok && col_ok)
            s_mem[addr_of(in_row[IDXW-1:0], in_col[IDXW-1:0])] <= in_cov;
        if (state_reg == ST_Q_B)
            q_mem[rd_addr] <= q_new;
        s_rd_reg  <= s_mem[rd_addr];
        q_rd_reg  <= q_mem[rd_addr];
        q_rdv_reg <= q_valid_reg[rd_addr];
        q_rdd_reg <= (i_reg == j_reg);
    end

    // Q entries not yet written read as the identity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= '0;
        else if (state_reg == ST_Q_B)
            q_valid_reg[rd_addr] <= 1'b1;
    end

    // Current period elements
    always_ff @(posedge clk)
    begin
        if (in_accept && (s_tuser == OP_ELEM) && row_ok)
        begin
            cur_res[in_row[IDXW-1:0]] <= in_res;
            cur_vol[in_row[IDXW-1:0]] <= in_vol;
        end
    end

    // Previous residuals and closed-period count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SERIES; k++)
                prev_res_reg[k] <= '0;
            period_count_reg <= '0;
        end
        else if (state_reg == ST_FINISH)
        begin
            for (int k = 0; k < SERIES; k++)
                prev_res_reg[k] <= cur_res[k];
            if (period_count_reg != 16'hffff)
                period_count_reg <= period_count_reg + 1'b1;
        end
    end

    // Arithmetic datapath
    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            ST_U_ST:   u_arr[i_reg] <= t_val;
            ST_Q_LI:   lat_reg <= u_sel;
            ST_Q_NEWS: news_reg <= t_val;
            ST_Q_C:    acc_reg <= prod_reg;
            ST_Q_A:    acc_reg <= q_sum;
            ST_D_SQW:  if (sq_stat.done) d_arr[i_reg] <= $signed(sq_root);
            ST_R_LI:   lat_reg <= d_sel;
            ST_R_DEN:  if (!den_pos) r_reg <= '0;
            ST_R_DIVW: if (div_stat.done) r_reg <= div_quo;
            default:   ;
        endcase
    end

    // Output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (emit)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_row_reg  <= 3'(i_reg);
            out_col_reg  <= 3'(j_reg);
            out_last_reg <= tri_last;
            if (state_reg == ST_SK_EMIT)
            begin
                out_corr_reg <= (i_reg == j_reg) ? ONE_Q : '0;
                out_cov_reg  <= s_rd_reg;
            end
            else
            begin
                out_corr_reg <= r_reg;
                out_cov_reg  <= t_val;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_cov_reg, out_corr_reg, out_col_reg, out_row_reg};

    // Serial units
    cdcc_sqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .x     (q_val),
        .stat  (sq_stat),
        .root  (sq_root)
    );

    cdcc_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (q_val),
        .den   (prod_sh[DW-1:0]),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // Checks
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tdata[2:0] == 3'(SERIES - 1)) &&
                                (m_tdata[5:3] == 3'(SERIES - 1)))
        else $error("last flag away from the final diagonal entry");

    a_upper_tri: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[5:3] >= m_tdata[2:0]))
        else $error("entry below the diagonal emitted");

    a_unit_start: assert property (@(posedge clk) disable iff (!rst_n)
        (!sq_start || !sq_stat.busy) && (!div_start || !div_stat.busy))
        else $error("serial unit restarted while busy");

    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (period_count_reg >= $past(period_count_reg)))
        else $error("period count went backward");

endmodule

`default_nettype wire

// ----- hw/rtl/cdcc_sqrt.sv -----
// Bit-serial floor square root of (x << FRAC_BITS), one root bit per cycle.
`default_nettype none

module cdcc_sqrt #(
    parameter int FRAC_BITS = cdcc_pkg::FRAC_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic signed [cdcc_pkg::DW-1:0] x,
    output cdcc_pkg::unit_stat_t             stat,
    output logic        [cdcc_pkg::DW-1:0]   root
);
    import cdcc_pkg::*;

    localparam int SQW = 32 + FRAC_BITS + (FRAC_BITS % 2);
    localparam int RW  = SQW / 2;
    localparam int CW  = $clog2(RW + 1);

    logic [SQW-1:0] rad_reg;
    logic [RW:0]    rem_reg;
    logic [RW-1:0]  root_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [RW+2:0]  rem_sh;
    logic [RW+2:0]  trial;
    logic           ge;
    logic [RW+2:0]  rem_dif;
    logic           x_pos;

    // One radicand digit pair per cycle
    always_comb
    begin
        rem_sh  = {rem_reg, rad_reg[SQW-1:SQW-2]};
        trial   = {1'b0, root_reg, 2'b01};
        ge      = (rem_sh >= trial);
        rem_dif = ge ? (rem_sh - trial) : rem_sh;
        x_pos   = !x[DW-1] && (x != '0);
    end

    // Control: busy while the counter runs down, then a one-cycle done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= x_pos ? SQW'({x[DW-2:0], {FRAC_BITS{1'b0}}}) : '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SQW-3:0], 2'b00};
            rem_reg  <= rem_dif[RW:0];
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = DW'(root_reg);

endmodule

`default_nettype wire

// ----- hw/rtl/cdcc_div.sv -----
// Bit-serial divider: (num << FRAC_BITS) / den, truncated toward zero, saturated.
`default_nettype none

module cdcc_div #(
    parameter int FRAC_BITS = cdcc_pkg::FRAC_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic signed [cdcc_pkg::DW-1:0] num,
    input  wire logic        [cdcc_pkg::DW-1:0] den,
    output cdcc_pkg::unit_stat_t                stat,
    output logic signed      [cdcc_pkg::DW-1:0] quo
);
    import cdcc_pkg::*;

    localparam int QW = DW + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0]  dq_reg;
    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  den_reg;
    logic           neg_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [DW:0]    rem_sh;
    logic [DW:0]    rem_dif;
    logic           ge;
    logic [DW-1:0]  mag;
    logic signed [63:0] q64;

    // One quotient bit per cycle, restoring
    always_comb
    begin
        rem_sh  = {rem_reg, dq_reg[QW-1]};
        ge      = (rem_sh >= {1'b0, den_reg});
        rem_dif = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        mag     = num[DW-1] ? (~num + 1'b1) : num;
        q64     = $signed({{(64-QW){1'b0}}, dq_reg});
        if (neg_reg)
            q64 = -q64;
        quo     = sat32(q64);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= {mag, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[DW-1];
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[QW-2:0], ge};
            rem_reg <= rem_dif[DW-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire
